// ===== src/i2c_eeb_pkg.sv =====
// Shared types, constants and helpers for the I2C EEPROM byte master.
// Used by the sequencer, the result queue and the top level. No dependencies.
`default_nettype none

package i2c_eeb_pkg;

	localparam int ADDR_W      = 17;
	localparam int ADDR_BITS_D = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_CYCLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ADDRESS = 3'd3;

	localparam logic [7:0]  RST_SHORT_DELAY = 8'd1;
	localparam logic [7:0]  RST_LONG_DELAY  = 8'd2;
	localparam logic [15:0] RST_WRITE_CYCLE = 16'd2500;
	localparam logic [ADDR_W-1:0] RST_MAX_ADDRESS = 17'h1FFFF;

	localparam logic [7:0] DEV_WRITE = 8'hA0;
	localparam logic [7:0] DEV_A16   = 8'h02;
	localparam logic [7:0] DEV_RD    = 8'h01;
	localparam logic [7:0] BYTE_NONE = 8'hFF;

	typedef struct packed {
		logic [7:0]        short_delay;
		logic [7:0]        long_delay;
		logic [15:0]       write_cycle_ticks;
		logic [ADDR_W-1:0] max_address;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda_oe;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] read_data;
		logic       done_res;
		logic       nack;
	} res_t;

	// A phase delay of zero still lasts one tick.
	function automatic logic [15:0] phase_len(input logic [15:0] d);
		phase_len = (d == 16'd0) ? 16'd1 : d;
	endfunction

	// Byte sent at position idx of a transaction.
	function automatic logic [7:0] byte_for(input logic [ADDR_W-1:0] addr,
			input logic op_rd, input logic [7:0] data, input logic [2:0] idx);
		logic [7:0] dev;
		dev = DEV_WRITE | (addr[16] ? DEV_A16 : 8'h00);
		case (idx)
			3'd0:    byte_for = dev;
			3'd1:    byte_for = addr[15:8];
			3'd2:    byte_for = addr[7:0];
			default: byte_for = op_rd ? (dev | DEV_RD) : data;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== src/i2c_eeb_seq.sv =====
// Bit-level bus sequencer: holds the transaction state and advances it by one
// item per accepted transfer. Depends on i2c_eeb_pkg.
`default_nettype none

module i2c_eeb_seq #(
	parameter int ADDR_BITS = i2c_eeb_pkg::ADDR_BITS_D
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire [1:0]                        kind,
	input  wire [i2c_eeb_pkg::ADDR_W-1:0]    address,
	input  wire [7:0]                        write_data,
	input  wire                              sda_in,
	input  i2c_eeb_pkg::cfg_t                cfg,
	output i2c_eeb_pkg::res_t                res
);
	import i2c_eeb_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_STA_A, PH_STA_B, PH_WB_LOW, PH_WB_DATA, PH_WB_HIGH,
		PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_HOLD, PH_ACK_END,
		PH_RB_LOW, PH_RB_HIGH, PH_RB_HOLD, PH_RB_TAIL,
		PH_NA_LOW, PH_NA_DATA, PH_NA_HIGH, PH_NA_END,
		PH_SP_A, PH_SP_B, PH_SP_C, PH_WCYC
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [3:0]           bits_q, bits_d;
	logic [7:0]           shift_q, shift_d;
	logic [15:0]          delay_q, delay_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic                 op_q, op_d;
	logic [7:0]           data_q, data_d;
	logic                 nack_q, nack_d;
	logic [2:0]           idx_q, idx_d;
	logic [7:0]           rd_q, rd_d;
	logic                 scl_q, scl_d;
	logic                 oe_q, oe_d;
	logic                 sda_q, sda_d;
	logic                 done_d;
	logic [ADDR_W-1:0]    addr_full;
	logic [2:0]           idx_inc;
	logic [15:0]          short_len, long_len;

	assign addr_full = ADDR_W'(addr_q);
	assign idx_inc   = idx_q + 3'd1;
	assign short_len = phase_len({8'd0, cfg.short_delay});
	assign long_len  = phase_len({8'd0, cfg.long_delay});

	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		delay_d = delay_q;
		addr_d  = addr_q;
		op_d    = op_q;
		data_d  = data_q;
		nack_d  = nack_q;
		idx_d   = idx_q;
		rd_d    = rd_q;
		scl_d   = scl_q;
		oe_d    = oe_q;
		sda_d   = sda_q;
		done_d  = 1'b0;
		if (kind == KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				if (delay_q > 16'd1) begin
					delay_d = delay_q - 16'd1;
				end else begin
					case (phase_q)
						PH_STA_A: begin
							sda_d = 1'b0; phase_d = PH_STA_B; delay_d = short_len;
						end
						PH_STA_B: begin
							shift_d = byte_for(addr_full, op_q, data_q, idx_q);
							bits_d = 4'd0; scl_d = 1'b0;
							phase_d = PH_WB_LOW; delay_d = long_len;
						end
						PH_WB_LOW: begin
							sda_d = shift_q[7]; shift_d = {shift_q[6:0], 1'b0};
							phase_d = PH_WB_DATA; delay_d = short_len;
						end
						PH_WB_DATA: begin
							scl_d = 1'b1; phase_d = PH_WB_HIGH; delay_d = long_len;
						end
						PH_WB_HIGH: begin
							bits_d = bits_q + 4'd1;
							scl_d = 1'b0;
							delay_d = long_len;
							if (bits_q < 4'd7) begin
								phase_d = PH_WB_LOW;
							end else begin
								oe_d = 1'b0; phase_d = PH_ACK_LOW;
							end
						end
						PH_ACK_LOW: begin
							scl_d = 1'b1; phase_d = PH_ACK_HIGH; delay_d = short_len;
						end
						PH_ACK_HIGH: begin
							nack_d = nack_q | sda_in;
							phase_d = PH_ACK_HOLD; delay_d = short_len;
						end
						PH_ACK_HOLD: begin
							scl_d = 1'b0; phase_d = PH_ACK_END; delay_d = long_len;
						end
						PH_ACK_END: begin
							if (nack_q) begin
								// The slave refused the byte: abort with a stop.
								if (op_q) rd_d = BYTE_NONE;
								oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0;
								phase_d = PH_SP_A; delay_d = long_len;
							end else begin
								idx_d = idx_inc;
								if ((!op_q && idx_inc < 3'd4) || (op_q && idx_inc < 3'd3)) begin
									oe_d = 1'b1;
									shift_d = byte_for(addr_full, op_q, data_q, idx_inc);
									bits_d = 4'd0; scl_d = 1'b0;
									phase_d = PH_WB_LOW; delay_d = long_len;
								end else if (!op_q) begin
									oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0;
									phase_d = PH_SP_A; delay_d = long_len;
								end else if (idx_inc == 3'd3) begin
									// Repeated start before the read device byte.
									oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
									phase_d = PH_STA_A; delay_d = long_len;
								end else begin
									shift_d = 8'd0; bits_d = 4'd0;
									scl_d = 1'b0; oe_d = 1'b0;
									phase_d = PH_RB_LOW; delay_d = long_len;
								end
							end
						end
						PH_RB_LOW: begin
							scl_d = 1'b1; phase_d = PH_RB_HIGH; delay_d = short_len;
						end
						PH_RB_HIGH: begin
							shift_d = {shift_q[6:0], sda_in};
							phase_d = PH_RB_HOLD; delay_d = short_len;
						end
						PH_RB_HOLD: begin
							bits_d = bits_q + 4'd1;
							if (bits_q < 4'd7) begin
								scl_d = 1'b0; phase_d = PH_RB_LOW; delay_d = long_len;
							end else begin
								phase_d = PH_RB_TAIL; delay_d = short_len;
							end
						end
						PH_RB_TAIL: begin
							rd_d = shift_q; scl_d = 1'b0; oe_d = 1'b1;
							phase_d = PH_NA_LOW; delay_d = long_len;
						end
						PH_NA_LOW: begin
							sda_d = 1'b1; phase_d = PH_NA_DATA; delay_d = short_len;
						end
						PH_NA_DATA: begin
							scl_d = 1'b1; phase_d = PH_NA_HIGH; delay_d = short_len;
						end
						PH_NA_HIGH: begin
							scl_d = 1'b0; phase_d = PH_NA_END; delay_d = long_len;
						end
						PH_NA_END: begin
							oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b0;
							phase_d = PH_SP_A; delay_d = long_len;
						end
						PH_SP_A: begin
							scl_d = 1'b1; phase_d = PH_SP_B; delay_d = short_len;
						end
						PH_SP_B: begin
							sda_d = 1'b1; phase_d = PH_SP_C; delay_d = long_len;
						end
						PH_SP_C: begin
							if (!op_q && !nack_q && cfg.write_cycle_ticks != 16'd0) begin
								phase_d = PH_WCYC; delay_d = cfg.write_cycle_ticks;
							end else begin
								phase_d = PH_IDLE; delay_d = 16'd0; done_d = 1'b1;
							end
						end
						default: begin
							phase_d = PH_IDLE; delay_d = 16'd0; done_d = 1'b1;
						end
					endcase
				end
			end
		end else if ((kind == KIND_WRITE || kind == KIND_READ) && phase_q == PH_IDLE) begin
			nack_d = 1'b0;
			if (kind == KIND_READ && address > cfg.max_address) begin
				rd_d = BYTE_NONE; done_d = 1'b1;
			end else begin
				addr_d = address[ADDR_BITS-1:0];
				op_d   = (kind == KIND_READ);
				data_d = write_data;
				idx_d  = 3'd0;
				oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
				phase_d = PH_STA_A; delay_d = long_len;
			end
		end
	end

	always_comb begin
		res.scl       = scl_d;
		res.sda_oe    = oe_d;
		res.sda_out   = sda_d;
		res.busy_res  = (phase_d != PH_IDLE);
		res.read_data = rd_d;
		res.done_res  = done_d;
		res.nack      = nack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bits_q  <= '0;
			shift_q <= '0;
			delay_q <= '0;
			addr_q  <= '0;
			op_q    <= 1'b0;
			data_q  <= '0;
			nack_q  <= 1'b0;
			idx_q   <= '0;
			rd_q    <= '0;
			scl_q   <= 1'b1;
			oe_q    <= 1'b0;
			sda_q   <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			delay_q <= delay_d;
			addr_q  <= addr_d;
			op_q    <= op_d;
			data_q  <= data_d;
			nack_q  <= nack_d;
			idx_q   <= idx_d;
			rd_q    <= rd_d;
			scl_q   <= scl_d;
			oe_q    <= oe_d;
			sda_q   <= sda_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/i2c_eeb_outq.sv =====
// Two-entry result queue between the sequencer and the output channel, so an
// input transfer is taken while a result still waits. Depends on i2c_eeb_pkg.
`default_nettype none

module i2c_eeb_outq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  i2c_eeb_pkg::res_t  push_data,
	output logic               full,
	output logic               pop_valid,
	input  wire                pop_stall,
	output i2c_eeb_pkg::res_t  pop_data
);
	import i2c_eeb_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && !pop_stall;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

// ===== src/i2c_eeprom_byte_master.sv =====
// Top level of the I2C EEPROM byte master: configuration registers, the bus
// sequencer and the result queue. Depends on i2c_eeb_pkg, i2c_eeb_seq, i2c_eeb_outq.
//
// Usage: every input transfer is either a one-microsecond tick or a command
// (byte write or byte read). Each input transfer produces exactly one result
// transfer holding the bus line levels, busy, the last read byte, a done
// pulse and the nack flag as they stand after that item.
// The sequencer steps once per accepted item, so one item is taken every
// clock cycle while in_stall is low; each result is registered in the queue
// before output. Bus timing is set purely by the tick count per phase, held
// in the short_delay, long_delay and write_cycle_ticks registers.
// A two-entry result queue lets the next item enter while a result waits;
// in_stall rises only when both entries are held by a stalled receiver.
// Configuration writes are taken in any cycle (cfg_ready is always high)
// and are meant to happen while the block is idle.
// Reset leaves the sequencer idle with the bus released (scl high, SDA not
// driven), the queue empty and the registers at their documented defaults.
`default_nettype none

module i2c_eeprom_byte_master #(
	parameter int ADDR_BITS = i2c_eeb_pkg::ADDR_BITS_D
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire [1:0]                            kind,
	input  wire [i2c_eeb_pkg::ADDR_W-1:0]        address,
	input  wire [7:0]                            write_data,
	input  wire                                  sda_in,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic                                 scl,
	output logic                                 sda_oe,
	output logic                                 sda_out,
	output logic                                 busy_res,
	output logic [7:0]                           read_data,
	output logic                                 done_res,
	output logic                                 nack,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [i2c_eeb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [i2c_eeb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import i2c_eeb_pkg::*;

	cfg_t cfg_q;
	res_t seq_res;
	res_t out_res;
	logic step;
	logic q_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign step      = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_delay       <= RST_SHORT_DELAY;
			cfg_q.long_delay        <= RST_LONG_DELAY;
			cfg_q.write_cycle_ticks <= RST_WRITE_CYCLE;
			cfg_q.max_address       <= RST_MAX_ADDRESS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHORT_DELAY: cfg_q.short_delay       <= cfg_data[7:0];
				REG_LONG_DELAY:  cfg_q.long_delay        <= cfg_data[7:0];
				REG_WRITE_CYCLE: cfg_q.write_cycle_ticks <= cfg_data[15:0];
				REG_MAX_ADDRESS: cfg_q.max_address       <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	i2c_eeb_seq #(
		.ADDR_BITS(ADDR_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.kind       (kind),
		.address    (address),
		.write_data (write_data),
		.sda_in     (sda_in),
		.cfg        (cfg_q),
		.res        (seq_res)
	);

	i2c_eeb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (seq_res),
		.full      (q_full),
		.pop_valid (out_valid),
		.pop_stall (out_stall),
		.pop_data  (out_res)
	);

	assign scl       = out_res.scl;
	assign sda_oe    = out_res.sda_oe;
	assign sda_out   = out_res.sda_out;
	assign busy_res  = out_res.busy_res;
	assign read_data = out_res.read_data;
	assign done_res  = out_res.done_res;
	assign nack      = out_res.nack;

endmodule

`default_nettype wire
